@@ hw/rtl/fwda_pkg.sv @@
// Shared types, constants and decimal weight helpers for the decimal ASCII formatter.
package fwda_pkg;

   localparam int unsigned VALUE_W = 16;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned WEIGHT_W = 17;

   localparam logic [7:0] ASCII_ZERO = 8'd48;
   localparam logic [7:0] ASCII_NINE = 8'd57;
   localparam logic [7:0] ASCII_DOT = 8'd46;

   localparam logic [COUNT_W-1:0] MIN_COUNT = 3'd2;
   localparam logic [COUNT_W-1:0] ABS_MAX_COUNT = 3'd5;

   // One formatting job handed from the input stage to the character sequencer.
   typedef struct packed {
      logic [VALUE_W-1:0] rem;    // saturated value still to print
      logic [COUNT_W-1:0] pidx;   // decimal weight index of the next digit
      logic               point;  // emit '.' after the first digit
      logic               ovf;    // value saturated to all nines
   } fwda_job_type;

   // 10^idx for idx 0..5.
   function automatic logic [WEIGHT_W-1:0] pow10(input logic [COUNT_W-1:0] idx);
      logic [WEIGHT_W-1:0] w;
      case (idx)
         3'd0: w = 17'd1;
         3'd1: w = 17'd10;
         3'd2: w = 17'd100;
         3'd3: w = 17'd1000;
         3'd4: w = 17'd10000;
         3'd5: w = 17'd100000;
         default: w = '0;
      endcase
      return w;
   endfunction

   // digit * 10^idx for digit 0..9, idx 0..4; a small constant table.
   function automatic logic [WEIGHT_W-1:0] digit_weight(input logic [3:0] digit,
                                                        input logic [COUNT_W-1:0] idx);
      logic [WEIGHT_W-1:0] w;
      case (idx)
         3'd0: w = 17'(digit);
         3'd1: w = 17'(digit) * 17'd10;
         3'd2: w = 17'(digit) * 17'd100;
         3'd3: w = 17'(digit) * 17'd1000;
         3'd4: w = 17'(digit) * 17'd10000;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/fwda_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
interface fwda_req_if;
   logic                            valid;
   logic                            ready;
   logic [fwda_pkg::VALUE_W-1:0]    value;
   logic [fwda_pkg::COUNT_W-1:0]    digit_count;
   logic                            point_after_first;

   modport source (output valid, output value, output digit_count,
                   output point_after_first, input ready);
   modport sink (input valid, input value, input digit_count,
                 input point_after_first, output ready);
endinterface

interface fwda_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;
   logic       overflowed;

   modport source (output valid, output char_code, output last_char,
                   output overflowed, input ready);
   modport sink (input valid, input char_code, input last_char,
                 input overflowed, output ready);
endinterface

@@ hw/rtl/fixed_width_decimal_ascii_core.sv @@
// Fixed-width decimal ASCII formatter: 16-bit unsigned value to 2..5 ASCII digits.
//
// Each request transaction carries a value, a digit count and a point flag; the core answers
// with one response transaction per character, most significant digit first, leading zeros
// kept, each digit as '0' + d. With the point flag set a '.' follows the first digit. A
// digit count below 2 is taken as 2 and one above MAX_DIGITS as MAX_DIGITS. A value of
// 10^count or more prints as all nines with overflowed set on every character of the run.
// last_char marks the final character. Rate: one character per clock while the receiver
// holds ready high; the digit sequencer feeds the single response register one character at
// a time. A new request is taken into the input register while the previous run is still
// being printed, so back-to-back requests stream with no gaps. The first character passes
// through the input register and the sequencer state before the response register
// presents it.
module fixed_width_decimal_ascii_core #(
   parameter int MAX_DIGITS = 5
) (
   input logic        clock,
   input logic        reset,
   fwda_req_if.sink   req_chan,
   fwda_rsp_if.source rsp_chan
);

   logic                   job_valid;
   logic                   job_ready;
   fwda_pkg::fwda_job_type job;

   // input register, count clamp and saturation
   fwda_prep #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_value  (req_chan.value),
      .in_count  (req_chan.digit_count),
      .in_point  (req_chan.point_after_first),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   // digit extraction by compare ladder, one character per cycle while the response side is free
   fwda_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_char  (rsp_chan.char_code),
      .rsp_last  (rsp_chan.last_char),
      .rsp_ovf   (rsp_chan.overflowed)
   );

endmodule

@@ hw/rtl/fwda_prep.sv @@
// Input register with digit count clamp and saturation to all nines.
module fwda_prep #(
   parameter int MAX_DIGITS = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [fwda_pkg::VALUE_W-1:0]  in_value,
   input  logic [fwda_pkg::COUNT_W-1:0]  in_count,
   input  logic                          in_point,
   output logic                          job_valid,
   input  logic                          job_ready,
   output fwda_pkg::fwda_job_type        job
);

   localparam logic [fwda_pkg::COUNT_W-1:0] MAX_CNT =
      (MAX_DIGITS < 2) ? fwda_pkg::MIN_COUNT :
      (MAX_DIGITS > 5) ? fwda_pkg::ABS_MAX_COUNT : fwda_pkg::COUNT_W'(MAX_DIGITS);

   logic                         a_valid_ff, a_valid_in;
   logic [fwda_pkg::VALUE_W-1:0] a_value_ff, a_value_in;
   logic [fwda_pkg::COUNT_W-1:0] a_count_ff, a_count_in;
   logic                         a_point_ff, a_point_in;

   logic [fwda_pkg::COUNT_W-1:0]  cnt;
   logic [fwda_pkg::WEIGHT_W-1:0] limit;
   logic                          ovf;
   logic                          accept;

   assign in_ready = !a_valid_ff || job_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_value_in = a_value_ff;
      a_count_in = a_count_ff;
      a_point_in = a_point_ff;
      if (accept) begin
         a_valid_in = 1'b1;
         a_value_in = in_value;
         a_count_in = in_count;
         a_point_in = in_point;
      end else if (job_ready) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_value_ff <= a_value_in;
      a_count_ff <= a_count_in;
      a_point_ff <= a_point_in;
   end

   // clamp count, then saturate anything that needs more digits
   always_comb begin
      if (a_count_ff < fwda_pkg::MIN_COUNT) begin
         cnt = fwda_pkg::MIN_COUNT;
      end else if (a_count_ff > MAX_CNT) begin
         cnt = MAX_CNT;
      end else begin
         cnt = a_count_ff;
      end
      limit = fwda_pkg::pow10(cnt);
      ovf   = {1'b0, a_value_ff} >= limit;
      job.rem   = ovf ? fwda_pkg::VALUE_W'(limit - 17'd1) : a_value_ff;
      job.pidx  = cnt - 3'd1;
      job.point = a_point_ff;
      job.ovf   = ovf;
   end

   assign job_valid = a_valid_ff;

endmodule

@@ hw/rtl/fwda_emit.sv @@
// Character sequencer: one digit or point per cycle into the response register while it is free.
module fwda_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  fwda_pkg::fwda_job_type  job,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_char,
   output logic                    rsp_last,
   output logic                    rsp_ovf
);

   logic                         busy_ff, busy_in;
   logic [fwda_pkg::VALUE_W-1:0] rem_ff, rem_in;
   logic [fwda_pkg::COUNT_W-1:0] pidx_ff, pidx_in;
   logic                         point_ff, point_in;   // point still owed after first digit
   logic                         dot_now_ff, dot_now_in;
   logic                         ovf_ff, ovf_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_last_ff, out_last_in;
   logic       out_ovf_ff, out_ovf_in;

   logic                          out_free;
   logic                          step;
   logic                          finish;
   logic [3:0]                    digit;
   logic [fwda_pkg::WEIGHT_W-1:0] sub;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = busy_ff && out_free;
   assign finish    = step && !dot_now_ff && (pidx_ff == '0);
   assign job_ready = !busy_ff || finish;

   // digit = largest k with k * 10^pidx <= rem
   always_comb begin
      digit = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if ({1'b0, rem_ff} >= fwda_pkg::digit_weight(4'(k), pidx_ff)) begin
            digit = 4'(k);
         end
      end
      sub = fwda_pkg::digit_weight(digit, pidx_ff);
   end

   always_comb begin
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      pidx_in      = pidx_ff;
      point_in     = point_ff;
      dot_now_in   = dot_now_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      if (step) begin
         out_valid_in = 1'b1;
         out_ovf_in   = ovf_ff;
         if (dot_now_ff) begin
            out_char_in = fwda_pkg::ASCII_DOT;
            out_last_in = 1'b0;
            dot_now_in  = 1'b0;
         end else begin
            out_char_in = fwda_pkg::ASCII_ZERO + 8'(digit);
            out_last_in = (pidx_ff == '0);
            rem_in      = rem_ff - fwda_pkg::VALUE_W'(sub);
            dot_now_in  = point_ff;
            point_in    = 1'b0;
            if (pidx_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               pidx_in = pidx_ff - 3'd1;
            end
         end
      end

      if (job_valid && job_ready) begin
         busy_in    = 1'b1;
         rem_in     = job.rem;
         pidx_in    = job.pidx;
         point_in   = job.point;
         dot_now_in = 1'b0;
         ovf_in     = job.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      rem_ff      <= rem_in;
      pidx_ff     <= pidx_in;
      point_ff    <= point_in;
      dot_now_ff  <= dot_now_in;
      ovf_ff      <= ovf_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_char  = out_char_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_ovf   = out_ovf_ff;

   // remainder always fits in the digits still to print
   a_rem_fits: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ({1'b0, rem_ff} < fwda_pkg::pow10(pidx_ff + 3'd1)))
      else $error("remainder exceeds remaining digit weight");

   // the point never closes a run
   a_dot_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_char_ff == fwda_pkg::ASCII_DOT) |-> !out_last_ff)
      else $error("point flagged as last character");

   // saturated runs print only nines and the point
   a_ovf_nines: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ovf_ff) |->
         (out_char_ff == fwda_pkg::ASCII_NINE || out_char_ff == fwda_pkg::ASCII_DOT))
      else $error("saturated run printed a digit other than nine");

   // a point is owed only before the first digit, a dot only after it
   a_point_order: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !(point_ff && dot_now_ff))
      else $error("point pending and point due at once");

endmodule

@@ test/fixed_width_decimal_ascii_core_test.sv @@
// Testbench for fixed_width_decimal_ascii_core: random and directed requests with a char scoreboard.
`timescale 1ns / 1ps

module fixed_width_decimal_ascii_core_test;

   localparam int MAX_DIGITS = 5;
   // Cycles with no transaction on either channel before the run is declared hung.
   localparam int HANG_LIMIT = 5000;
   // Extra wait after the last expected character, so any stray transaction can show up.
   localparam int DRAIN_CYCLES = 12;

   // One expected response transaction.
   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       ovf;
   } ascii_char_type;

   // Predicts the characters of each accepted request and checks every response against them.
   class ascii_run_checker;
      ascii_char_type pending_chars[$];
      int unsigned errors;
      int unsigned widest;

      function new(int unsigned max_digits);
         widest = max_digits;
         if (widest < fwda_pkg::MIN_COUNT) widest = fwda_pkg::MIN_COUNT;
         if (widest > fwda_pkg::ABS_MAX_COUNT) widest = fwda_pkg::ABS_MAX_COUNT;
         errors = 0;
      endfunction

      // Expand one accepted request into its run of characters.
      function void note_request(logic [fwda_pkg::VALUE_W-1:0] value,
                                 logic [fwda_pkg::COUNT_W-1:0] count,
                                 logic point);
         int unsigned    digits, limit, v, weight, total, k;
         logic           ovf;
         ascii_char_type c;
         digits = count;
         if (digits < fwda_pkg::MIN_COUNT) digits = fwda_pkg::MIN_COUNT;
         if (digits > widest) digits = widest;
         limit = 1;
         repeat (digits) limit = limit * 10;
         ovf = (value >= limit);
         v = ovf ? limit - 1 : value;
         total = digits + (point ? 1 : 0);
         weight = limit / 10;
         k = 0;
         for (int i = 0; i < digits; i++) begin
            c.code = fwda_pkg::ASCII_ZERO + 8'((v / weight) % 10);
            c.last = (k + 1 == total);
            c.ovf = ovf;
            pending_chars.push_back(c);
            k++;
            if (i == 0 && point) begin
               c.code = fwda_pkg::ASCII_DOT;
               c.last = (k + 1 == total);
               pending_chars.push_back(c);
               k++;
            end
            weight = weight / 10;
         end
      endfunction

      function void check_char(logic [7:0] code, logic last, logic ovf);
         ascii_char_type want;
         if (pending_chars.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected char: code %0d last %0b ovf %0b", code, last, ovf);
            return;
         end
         want = pending_chars.pop_front();
         if (code !== want.code || last !== want.last || ovf !== want.ovf) begin
            errors++;
            if (errors <= 10)
               $display("char mismatch: expected code %0d last %0b ovf %0b, got %0d %0b %0b",
                        want.code, want.last, want.ovf, code, last, ovf);
         end
      endfunction

      function int unsigned pending_count();
         return pending_chars.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   fwda_req_if req_bus();
   fwda_rsp_if rsp_bus();

   fixed_width_decimal_ascii_core #(
      .MAX_DIGITS(MAX_DIGITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   ascii_run_checker runs = new(MAX_DIGITS);

   // Idle percentages for the current phase: sender gaps and receiver stalls.
   int gap_pct = 0;
   int stall_pct = 0;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Known values on every input from time zero.
   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.digit_count <= '0;
      req_bus.point_after_first <= 1'b0;
      rsp_bus.ready <= 1'b0;
   end

   // Receiver: check each accepted response transaction, then pick ready for the next cycle.
   // Signals are sampled right after the edge, before any register update lands.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            runs.check_char(rsp_bus.char_code, rsp_bus.last_char, rsp_bus.overflowed);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Hang detector: any transaction on either side clears the count.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < HANG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // Present one request, with random gaps ahead of it, and hold it until accepted.
   // valid is only lowered for a gap, so it never gets two assignments in one step.
   task automatic send_request(logic [fwda_pkg::VALUE_W-1:0] value,
                               logic [fwda_pkg::COUNT_W-1:0] count,
                               logic point);
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      req_bus.digit_count <= count;
      req_bus.point_after_first <= point;
      do
         @(posedge clock);
      while (!req_bus.ready);
      runs.note_request(value, count, point);
   endtask

   // Random request: mostly legal counts, values spread over small, boundary and full range.
   task automatic send_random_request();
      logic [fwda_pkg::COUNT_W-1:0] count;
      int unsigned                  digits, limit, v;
      if ($urandom_range(9) == 0)
         count = fwda_pkg::COUNT_W'($urandom_range(7));
      else
         count = fwda_pkg::COUNT_W'($urandom_range(fwda_pkg::ABS_MAX_COUNT,
                                                   fwda_pkg::MIN_COUNT));
      digits = (count < fwda_pkg::MIN_COUNT) ? fwda_pkg::MIN_COUNT :
               (count > MAX_DIGITS) ? MAX_DIGITS : count;
      limit = 1;
      repeat (digits) limit = limit * 10;
      case ($urandom_range(3))
         0: v = $urandom_range(65535);
         1: v = (limit > 65535) ? $urandom_range(65535, 60000)
                                : $urandom_range(limit + 3, limit - 3);
         2: v = (limit > 65535) ? $urandom_range(65535) : $urandom_range(limit - 1);
         default: v = $urandom_range(limit > 65535 ? 65535 : limit * 2);
      endcase
      if (v > 65535) v = 65535;
      send_request(fwda_pkg::VALUE_W'(v), count, 1'($urandom_range(1)));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: range ends, every count including the clamped ones, boundaries, both points.
      send_request(16'd0, 3'd2, 1'b0);
      send_request(16'd0, 3'd5, 1'b1);
      send_request(16'd65535, 3'd5, 1'b0);
      send_request(16'd65535, 3'd5, 1'b1);
      send_request(16'd65535, 3'd2, 1'b1);
      send_request(16'd99, 3'd2, 1'b0);
      send_request(16'd100, 3'd2, 1'b1);
      send_request(16'd999, 3'd3, 1'b1);
      send_request(16'd1000, 3'd3, 1'b0);
      send_request(16'd9999, 3'd4, 1'b0);
      send_request(16'd10000, 3'd4, 1'b1);
      send_request(16'd12345, 3'd5, 1'b1);
      send_request(16'd2047, 3'd4, 1'b1);
      // Count below the minimum is taken as two.
      send_request(16'd7, 3'd0, 1'b1);
      send_request(16'd42, 3'd1, 1'b0);
      send_request(16'd123, 3'd1, 1'b1);
      // Count above the maximum is taken as five.
      send_request(16'd54321, 3'd6, 1'b0);
      send_request(16'd31, 3'd7, 1'b1);
      send_request(16'hAAAA, 3'd7, 1'b0);
      send_request(16'h5555, 3'd3, 1'b1);
      send_request(16'd10, 3'd2, 1'b0);

      // Random phases: no idling, sender gaps, receiver stalls, then both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 53; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 53; end
            default: begin gap_pct = 29; stall_pct = 29; end
         endcase
         repeat (60) send_random_request();
      end

      req_bus.valid <= 1'b0;
      gap_pct = 0;
      stall_pct = 0;
      while (runs.pending_count() > 0)
         @(posedge clock);
      // Let any stray trailing transaction show up before judging.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (runs.errors == 0 && runs.pending_count() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
